[src/kqld_pkg.sv]
// Shared types, constants and the half-to-single conversion for the lane dequantiser.
`default_nettype none
package kqld_pkg;

  // Format register codes.
  localparam logic [1:0] FMT_Q4 = 2'd0;
  localparam logic [1:0] FMT_Q5 = 2'd1;
  localparam logic [1:0] FMT_Q6 = 2'd2;

  // IEEE single and half constants.
  localparam logic [7:0]  EXP_MAX     = 8'hff;
  localparam logic [31:0] QNAN_BIT    = 32'h0040_0000;
  localparam logic [31:0] DEFAULT_NAN = 32'hffc0_0000;
  localparam logic [7:0]  BIAS_ADJ    = 8'd112;
  localparam logic [7:0]  SUBN_BASE   = 8'd103;
  localparam logic [4:0]  HALF_EXP_MAX = 5'h1f;

  // Cycles from the issue register to the lane result.
  localparam int LANE_LAT = 4;

  // Operands of one weight computation.
  typedef struct packed {
    logic [31:0]       d;
    logic [31:0]       dm;
    logic signed [8:0] sc;
    logic signed [8:0] mn;
    logic signed [8:0] q;
    logic              six;
  } lane_op_t;

  // Position and end mark of one result.
  typedef struct packed {
    logic [9:0] index;
    logic       last;
  } tag_t;

  // Converts half bits to single bits exactly, subnormals normalised.
  function automatic logic [31:0] half_to_single(input logic [15:0] h);
    logic [4:0]  ex;
    logic [9:0]  fr;
    logic [3:0]  p;
    logic [9:0]  nf;
    logic [31:0] r;
    ex = h[14:10];
    fr = h[9:0];
    p = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (fr[i]) p = 4'(i);
    end
    nf = fr << (4'd10 - p);
    if (ex == 5'd0) begin
      r = (fr == 10'd0) ? {h[15], 31'd0} : {h[15], SUBN_BASE + {4'd0, p}, nf, 13'd0};
    end else if (ex == HALF_EXP_MAX) begin
      r = {h[15], EXP_MAX, fr, 13'd0};
    end else begin
      r = {h[15], {3'd0, ex} + BIAS_ADJ, fr, 13'd0};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[src/kqld_fmul_int.sv]
// Single-precision multiply of a float by a small signed integer, rounded to nearest even.
`default_nettype none
module kqld_fmul_int (
  input  logic [31:0]       a,
  input  logic signed [8:0] n,
  output logic [31:0]       y
);
  import kqld_pkg::*;

  logic        neg;
  logic        sgn;
  logic [8:0]  nneg;
  logic [7:0]  mag;
  logic [7:0]  ea;
  logic [31:0] prod;
  logic [3:0]  t;
  logic [31:0] low;
  logic [31:0] half;
  logic [31:0] keep;
  logic        up;
  logic [24:0] rnd;
  logic [7:0]  eo;

  // Exact product, then a right shift of at most eight places with rounding.
  always_comb begin
    neg  = n[8];
    nneg = -n;
    mag  = neg ? nneg[7:0] : n[7:0];
    ea   = a[30:23];
    sgn  = a[31] ^ neg;
    prod = {8'd0, 1'b1, a[22:0]} * {24'd0, mag};
    t = 4'd0;
    for (int i = 0; i < 9; i++) begin
      if (prod[23+i]) t = 4'(i);
    end
    low  = prod & ((32'd1 << t) - 32'd1);
    half = (t == 4'd0) ? 32'd0 : (32'd1 << (t - 4'd1));
    keep = prod >> t;
    up   = (t != 4'd0) && ((low > half) || ((low == half) && keep[0]));
    rnd  = {1'b0, keep[23:0]} + {24'd0, up};
    eo   = ea + {4'd0, t} + {7'd0, rnd[24]};
    if (ea == EXP_MAX) begin
      if (a[22:0] != 23'd0) y = a | QNAN_BIT;
      else if (mag == 8'd0) y = DEFAULT_NAN;
      else y = {sgn, a[30:0]};
    end else if (ea == 8'd0 || mag == 8'd0) begin
      y = {sgn, 31'd0};
    end else begin
      y = {sgn, eo, rnd[24] ? 23'd0 : rnd[22:0]};
    end
  end

endmodule
`default_nettype wire

[src/kqld_fsub.sv]
// Two-stage single-precision subtractor a - b, rounded to nearest even.
`default_nettype none
module kqld_fsub (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] y
);
  import kqld_pkg::*;

  logic [31:0] bn;
  logic [31:0] big;
  logic [31:0] sml;
  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  logic        spec_w;
  logic [31:0] specv_w;
  logic [7:0]  diff;
  logic [26:0] mb;
  logic [26:0] ms;
  logic [26:0] al;
  logic        st;
  logic [26:0] als;
  logic [27:0] sum_w;

  logic        spec;
  logic [31:0] specv;
  logic [27:0] sum;
  logic [7:0]  eb;
  logic        sb;

  logic [4:0]  lz;
  logic [26:0] nrm;
  logic [7:0]  en;
  logic        up;
  logic [24:0] m25;
  logic [7:0]  ef;
  logic [31:0] y_next;

  // Stage one: special operands, operand swap, alignment and the add.
  always_comb begin
    bn     = {~b[31], b[30:0]};
    a_nan  = (a[30:23] == EXP_MAX) && (a[22:0] != 23'd0);
    b_nan  = (b[30:23] == EXP_MAX) && (b[22:0] != 23'd0);
    a_inf  = (a[30:23] == EXP_MAX) && (a[22:0] == 23'd0);
    b_inf  = (b[30:23] == EXP_MAX) && (b[22:0] == 23'd0);
    a_zero = (a[30:23] == 8'd0);
    b_zero = (b[30:23] == 8'd0);
    spec_w  = 1'b1;
    specv_w = 32'd0;
    priority if (a_nan) begin
      specv_w = a | QNAN_BIT;
    end else if (b_nan) begin
      specv_w = b | QNAN_BIT;
    end else if (a_inf && b_inf) begin
      specv_w = (a[31] == bn[31]) ? a : DEFAULT_NAN;
    end else if (a_inf) begin
      specv_w = a;
    end else if (b_inf) begin
      specv_w = bn;
    end else if (a_zero && b_zero) begin
      specv_w = {a[31] & bn[31], 31'd0};
    end else begin
      spec_w = 1'b0;
    end
    if (a[30:0] >= bn[30:0]) begin
      big = a;
      sml = bn;
    end else begin
      big = bn;
      sml = a;
    end
    diff = big[30:23] - sml[30:23];
    mb   = {big[30:23] != 8'd0, big[22:0], 3'd0};
    ms   = {sml[30:23] != 8'd0, sml[22:0], 3'd0};
    if (diff >= 8'd27) begin
      al = 27'd0;
      st = (ms != 27'd0);
    end else begin
      al = ms >> diff;
      st = ((ms & ((27'd1 << diff) - 27'd1)) != 27'd0);
    end
    als   = {al[26:1], al[0] | st};
    sum_w = (big[31] ^ sml[31]) ? ({1'b0, mb} - {1'b0, als}) : ({1'b0, mb} + {1'b0, als});
  end

  always_ff @(posedge clk) begin
    spec  <= spec_w;
    specv <= specv_w;
    sum   <= sum_w;
    eb    <= big[30:23];
    sb    <= big[31];
  end

  // Stage two: leading-zero search, normalisation and rounding.
  always_comb begin
    lz = 5'd0;
    for (int i = 0; i < 27; i++) begin
      if (sum[i]) lz = 5'(26 - i);
    end
    if (sum[27]) begin
      nrm = {sum[27:2], sum[1] | sum[0]};
      en  = eb + 8'd1;
    end else begin
      nrm = sum[26:0] << lz;
      en  = eb - {3'd0, lz};
    end
    up  = nrm[2] & (nrm[1] | nrm[0] | nrm[3]);
    m25 = {1'b0, nrm[26:3]} + {24'd0, up};
    ef  = en + {7'd0, m25[24]};
    if (spec) y_next = specv;
    else if (sum == 28'd0) y_next = 32'd0;
    else y_next = {sb, ef, m25[24] ? 23'd0 : m25[22:0]};
  end

  always_ff @(posedge clk) begin
    y <= y_next;
  end

endmodule
`default_nettype wire

[src/kqld_lane.sv]
// One dequantising lane: (d*scale)*q minus dmin*min, or (d*scale)*q in six-bit format.
`default_nettype none
module kqld_lane (
  input  logic               clk,
  input  kqld_pkg::lane_op_t op,
  output logic [31:0]        y
);
  import kqld_pkg::*;

  logic [31:0]       p_w, m_w, r_w, sub_w;
  logic [31:0]       p1, m1, r2, m2, r3, r4;
  logic signed [8:0] q1;
  logic              six1, six2, six3, six4;

  kqld_fmul_int u_mul_ds (.a(op.d),  .n(op.sc), .y(p_w));
  kqld_fmul_int u_mul_mn (.a(op.dm), .n(op.mn), .y(m_w));
  kqld_fmul_int u_mul_q  (.a(p1),    .n(q1),    .y(r_w));
  kqld_fsub     u_sub    (.clk(clk), .a(r2), .b(m2), .y(sub_w));

  // Scale products, then the quant product, then the subtraction.
  always_ff @(posedge clk) begin
    p1   <= p_w;
    m1   <= m_w;
    q1   <= op.q;
    six1 <= op.six;
    r2   <= r_w;
    m2   <= m1;
    six2 <= six1;
    r3   <= r2;
    six3 <= six2;
    r4   <= r3;
    six4 <= six3;
  end

  // The six-bit format skips the minimum term.
  assign y = six4 ? r4 : sub_w;

endmodule
`default_nettype wire

[src/kquant_lane_dequantizer.sv]
// Top level of the k-quant lane dequantiser: item register, issue sequencer, lanes, merge.
//
// Channel   Direction  Handshake                      Payload
// request   in         start & !busy                  lane, word_a, word_b, high_bits,
//                                                     d_half, dmin_half, factor0..factor3
// config    in         cfg_valid & cfg_ready          cfg_data (format)
// result    out        result_valid, one cycle each   element_index, value_a, value_b, last
//
// A request yields eight results on consecutive cycles; they pass through the item register,
// the issue register, the lane pipeline and the result register. The next request is taken in
// the cycle the previous one issues its last pair, so the two lanes and the result port stay
// busy without gaps.
// Reset clears the format register, the sequencer and all valid flags.
// The receiver cannot stall; cfg_ready is always high.
`default_nettype none
module kquant_lane_dequantizer (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [5:0]  lane,
  input  logic [31:0] word_a,
  input  logic [31:0] word_b,
  input  logic [31:0] high_bits,
  input  logic [15:0] d_half,
  input  logic [15:0] dmin_half,
  input  logic [7:0]  factor0,
  input  logic [7:0]  factor1,
  input  logic [7:0]  factor2,
  input  logic [7:0]  factor3,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data,
  output logic        result_valid,
  output logic [9:0]  element_index,
  output logic [31:0] value_a,
  output logic [31:0] value_b,
  output logic        last
);
  import kqld_pkg::*;

  logic        take;
  logic [1:0]  fmt;
  logic        itm_valid;
  logic [2:0]  cnt;
  logic [5:0]  itm_lane;
  logic [31:0] itm_wa, itm_wb, itm_hw, itm_d, itm_dm;
  logic [7:0]  fac [4];

  logic        part;
  logic [1:0]  j;
  logic [3:0]  la, lb;
  logic [7:0]  hb;
  logic [1:0]  ha6, hb6;
  logic        six;
  lane_op_t    opa_w, opb_w, opa, opb;
  tag_t        tag_w;
  logic        vld [LANE_LAT+1];
  tag_t        tag [LANE_LAT+1];
  logic [31:0] ya, yb;

  assign cfg_ready = 1'b1;
  assign take      = start && !busy;
  assign busy      = itm_valid && (cnt != 3'd7);

  // Format register.
  always_ff @(posedge clk) begin
    if (rst) begin
      fmt <= FMT_Q4;
    end else if (cfg_valid && cfg_ready) begin
      fmt <= cfg_data;
    end
  end

  // Item register and the sequencer over the eight result pairs.
  always_ff @(posedge clk) begin
    if (rst) begin
      itm_valid <= 1'b0;
      cnt       <= 3'd0;
    end else if (take) begin
      itm_valid <= 1'b1;
      cnt       <= 3'd0;
    end else if (itm_valid) begin
      cnt <= cnt + 3'd1;
      if (cnt == 3'd7) itm_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      itm_lane <= lane;
      itm_wa   <= word_a;
      itm_wb   <= word_b;
      itm_hw   <= high_bits;
      itm_d    <= half_to_single(d_half);
      itm_dm   <= half_to_single(dmin_half);
      fac[0]   <= factor0;
      fac[1]   <= factor1;
      fac[2]   <= factor2;
      fac[3]   <= factor3;
    end
  end

  // Operand selection for the current part and byte.
  always_comb begin
    part = cnt[2];
    j    = cnt[1:0];
    la   = 4'(itm_wa >> {j, part, 2'b00});
    lb   = 4'(itm_wb >> {j, part, 2'b00});
    hb   = 8'(itm_hw >> {j, 3'b000});
    ha6  = part ? hb[5:4] : hb[1:0];
    hb6  = part ? hb[7:6] : hb[3:2];
    six  = (fmt != FMT_Q4) && (fmt != FMT_Q5);
    opa_w.d   = itm_d;
    opa_w.dm  = itm_dm;
    opa_w.six = six;
    opb_w.d   = itm_d;
    opb_w.dm  = itm_dm;
    opb_w.six = six;
    if (six) begin
      opa_w.sc = {fac[{part, 1'b0}][7], fac[{part, 1'b0}]};
      opb_w.sc = {fac[{part, 1'b1}][7], fac[{part, 1'b1}]};
      opa_w.mn = 9'sd0;
      opb_w.mn = 9'sd0;
      opa_w.q  = $signed({3'd0, ha6, la} - 9'd32);
      opb_w.q  = $signed({3'd0, hb6, lb} - 9'd32);
    end else begin
      opa_w.sc = {1'b0, fac[{1'b0, part}]};
      opb_w.sc = {1'b0, fac[{1'b0, part}]};
      opa_w.mn = {1'b0, fac[{1'b1, part}]};
      opb_w.mn = {1'b0, fac[{1'b1, part}]};
      opa_w.q  = {4'd0, (fmt == FMT_Q5) & hb[{1'b0, part}], la};
      opb_w.q  = {4'd0, (fmt == FMT_Q5) & hb[{1'b1, part}], lb};
    end
    tag_w.index = {itm_lane[5:2], part, 1'b0, itm_lane[1:0], j};
    tag_w.last  = (cnt == 3'd7);
  end

  // Issue register feeding both lanes.
  always_ff @(posedge clk) begin
    opa <= opa_w;
    opb <= opb_w;
  end

  kqld_lane u_lane_a (.clk(clk), .op(opa), .y(ya));
  kqld_lane u_lane_b (.clk(clk), .op(opb), .y(yb));

  // Tags travel alongside the lanes.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= LANE_LAT; i++) vld[i] <= 1'b0;
    end else begin
      vld[0] <= itm_valid;
      for (int i = 1; i <= LANE_LAT; i++) vld[i] <= vld[i-1];
    end
  end

  always_ff @(posedge clk) begin
    tag[0] <= tag_w;
    for (int i = 1; i <= LANE_LAT; i++) tag[i] <= tag[i-1];
  end

  // Merge the two lane values with their tag into the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= vld[LANE_LAT];
    end
    element_index <= tag[LANE_LAT].index;
    last          <= tag[LANE_LAT].last;
    value_a       <= ya;
    value_b       <= yb;
  end

  // A taken request keeps the sequencer occupied in the next cycle.
  assert property (@(posedge clk) disable iff (rst) take |=> busy)
    else $error("request taken but sequencer not occupied");

  // Results of one request follow each other without gaps.
  assert property (@(posedge clk) disable iff (rst) (result_valid && !last) |=> result_valid)
    else $error("gap inside the results of one request");

  // The first result after a gap is part zero, byte zero.
  assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> (element_index[5] == 1'b0 && element_index[1:0] == 2'd0))
    else $error("result sequence did not start at its first pair");

endmodule
`default_nettype wire

[sim/tb_kquant_lane_dequantizer.sv]
// Self-checking testbench for the k-quant lane dequantiser, with its weight scoreboard.
`timescale 1ns / 1ps
`default_nettype none
module tb_kquant_lane_dequantizer;
  import kqld_pkg::*;

  localparam int RUN_LIMIT = 400000;
  localparam logic [31:0] NAN_QUIET = 32'h0040_0000;
  localparam logic [31:0] NAN_INVALID = 32'hffc0_0000;

  // One expected weight pair with its tile position.
  typedef struct {
    logic [9:0]  index;
    logic [31:0] va;
    logic [31:0] vb;
    logic        last;
  } weight_pair_t;

  // Scoreboard: predicts the weight pairs of each request and checks the results.
  class weight_scoreboard;
    weight_pair_t pending_pairs[$];
    logic [1:0]   format;
    int           errors;

    function new();
      format = FMT_Q4;
      errors = 0;
    endfunction

    // Rounds sig * 2^e to single precision, nearest even, with subnormals.
    function logic [31:0] round_pack(bit s, int e, logic [63:0] sig);
      int p, bexp, lsbw, sh;
      logic [63:0] m;
      bit rnd, stk;
      if (sig == 64'd0) return {s, 31'd0};
      p = 63;
      while (!sig[p]) p--;
      bexp = e + p + 127;
      lsbw = (bexp >= 1) ? e + p - 23 : -149;
      sh = lsbw - e;
      rnd = 1'b0;
      stk = 1'b0;
      if (sh <= 0) begin
        m = sig << (-sh);
      end else if (sh > 64) begin
        m = 64'd0;
        stk = 1'b1;
      end else begin
        m = sig >> sh;
        rnd = sig[sh-1];
        stk = |(sig & ((64'd1 << (sh - 1)) - 64'd1));
      end
      if (rnd && (stk || m[0])) m = m + 64'd1;
      if (bexp >= 1) begin
        if (m[24]) begin
          m = m >> 1;
          bexp++;
        end
        if (bexp >= 255) return {s, 8'hff, 23'd0};
        return {s, bexp[7:0], m[22:0]};
      end
      return {s, 31'd0} + m[31:0];
    endfunction

    // Splits a finite single into sign, exponent of its lowest bit and significand.
    function void unpack(logic [31:0] a, output bit s, output int e, output logic [63:0] sig);
      s = a[31];
      if (a[30:23] == 8'd0) begin
        e = -149;
        sig = {41'd0, a[22:0]};
      end else begin
        e = int'(a[30:23]) - 150;
        sig = {40'd0, 1'b1, a[22:0]};
      end
    endfunction

    function bit is_nan(logic [31:0] a);
      return a[30:23] == 8'hff && a[22:0] != 23'd0;
    endfunction

    function bit is_inf(logic [31:0] a);
      return a[30:23] == 8'hff && a[22:0] == 23'd0;
    endfunction

    function bit is_zero(logic [31:0] a);
      return a[30:0] == 31'd0;
    endfunction

    // Single-precision product; the first NaN operand is propagated quietened.
    function logic [31:0] fmul(logic [31:0] a, logic [31:0] b);
      bit sa, sb;
      int ea, eb;
      logic [63:0] ma, mb;
      if (is_nan(a)) return a | NAN_QUIET;
      if (is_nan(b)) return b | NAN_QUIET;
      if (is_inf(a) || is_inf(b)) begin
        if (is_zero(a) || is_zero(b)) return NAN_INVALID;
        return {a[31] ^ b[31], 8'hff, 23'd0};
      end
      if (is_zero(a) || is_zero(b)) return {a[31] ^ b[31], 31'd0};
      unpack(a, sa, ea, ma);
      unpack(b, sb, eb, mb);
      return round_pack(sa ^ sb, ea + eb, ma * mb);
    endfunction

    // Single-precision sum with a sticky-jammed alignment of the smaller operand.
    function logic [31:0] fadd(logic [31:0] a, logic [31:0] b);
      bit sa, sb, so;
      int ea, eb, shamt;
      logic [63:0] ma, mb, big, lit, sum;
      if (is_nan(a)) return a | NAN_QUIET;
      if (is_nan(b)) return b | NAN_QUIET;
      if (is_inf(a) && is_inf(b)) return (a[31] != b[31]) ? NAN_INVALID : a;
      if (is_inf(a)) return a;
      if (is_inf(b)) return b;
      if (is_zero(a) && is_zero(b)) return {a[31] & b[31], 31'd0};
      if (is_zero(a)) return b;
      if (is_zero(b)) return a;
      unpack(a, sa, ea, ma);
      unpack(b, sb, eb, mb);
      if (eb > ea) begin
        unpack(b, sa, ea, ma);
        unpack(a, sb, eb, mb);
      end
      shamt = ea - eb;
      big = ma << 32;
      lit = mb << 32;
      if (shamt >= 64) lit = 64'd1;
      else if (shamt > 0) lit = (lit >> shamt) | {63'd0, |(lit & ((64'd1 << shamt) - 64'd1))};
      if (sa == sb) begin
        sum = big + lit;
        so = sa;
      end else if (big >= lit) begin
        sum = big - lit;
        so = sa;
      end else begin
        sum = lit - big;
        so = sb;
      end
      if (sum == 64'd0) return 32'd0;
      return round_pack(so, ea - 32, sum);
    endfunction

    // Single-precision difference; a NaN subtrahend keeps its own sign.
    function logic [31:0] fsub(logic [31:0] a, logic [31:0] b);
      if (is_nan(a)) return a | NAN_QUIET;
      if (is_nan(b)) return b | NAN_QUIET;
      return fadd(a, b ^ 32'h8000_0000);
    endfunction

    function logic [31:0] from_int(int v);
      return round_pack(v < 0, 0, 64'(v < 0 ? -v : v));
    endfunction

    // Widens half bits to single bits; subnormal halves are exact in single.
    function logic [31:0] widen_half(logic [15:0] h);
      if (h[14:10] == 5'd0) return round_pack(h[15], -24, {54'd0, h[9:0]});
      if (h[14:10] == 5'h1f) return {h[15], 8'hff, h[9:0], 13'd0};
      return {h[15], 8'(h[14:10]) + 8'd112, h[9:0], 13'd0};
    endfunction

    // Predicts the eight weight pairs of one accepted request.
    function void note_request(logic [5:0] ln, logic [31:0] wa, logic [31:0] wb,
                               logic [31:0] hw, logic [15:0] dh, logic [15:0] dmh,
                               logic [7:0] f[4]);
      logic [31:0] d, dm, sca, scb, mn;
      logic [7:0]  hb;
      int qa, qb, k, sh;
      weight_pair_t wp;
      d = widen_half(dh);
      dm = widen_half(dmh);
      k = 0;
      for (int part = 0; part < 2; part++) begin
        for (int j = 0; j < 4; j++) begin
          sh = 4 * part + 8 * j;
          qa = int'((wa >> sh) & 32'hf);
          qb = int'((wb >> sh) & 32'hf);
          hb = hw[8*j +: 8];
          if (format[1]) begin
            // Six-bit signed: two high bits per value, offset of 32, no minimum.
            qa = (qa | (int'(hb[(part ? 4 : 0) +: 2]) << 4)) - 32;
            qb = (qb | (int'(hb[(part ? 6 : 2) +: 2]) << 4)) - 32;
            sca = from_int(int'($signed(f[2*part])));
            scb = from_int(int'($signed(f[2*part+1])));
            wp.va = fmul(fmul(d, sca), from_int(qa));
            wp.vb = fmul(fmul(d, scb), from_int(qb));
          end else begin
            if (format == FMT_Q5) begin
              qa = qa | (int'(hb[part]) << 4);
              qb = qb | (int'(hb[2+part]) << 4);
            end
            sca = from_int(int'(f[part]));
            mn = fmul(dm, from_int(int'(f[2+part])));
            wp.va = fsub(fmul(fmul(d, sca), from_int(qa)), mn);
            wp.vb = fsub(fmul(fmul(d, sca), from_int(qb)), mn);
          end
          wp.index = 10'((ln >> 4) * 256 + 32 * (2 * ((ln >> 2) & 3) + part) +
                         4 * (ln & 3) + j);
          wp.last = (k == 7);
          pending_pairs.push_back(wp);
          k++;
        end
      end
    endfunction

    // Compares one result against the oldest predicted pair.
    function void check_result(logic [9:0] idx, logic [31:0] va, logic [31:0] vb,
                               logic lst);
      weight_pair_t wp;
      if (pending_pairs.size() == 0) begin
        $display("%0t: unexpected result index %0d", $time, idx);
        errors++;
        return;
      end
      wp = pending_pairs.pop_front();
      if (idx !== wp.index) begin
        $display("%0t: element_index expected %0d actual %0d", $time, wp.index, idx);
        errors++;
      end
      if (va !== wp.va) begin
        $display("%0t: value_a expected %h actual %h", $time, wp.va, va);
        errors++;
      end
      if (vb !== wp.vb) begin
        $display("%0t: value_b expected %h actual %h", $time, wp.vb, vb);
        errors++;
      end
      if (lst !== wp.last) begin
        $display("%0t: last expected %b actual %b", $time, wp.last, lst);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [5:0]  lane = '0;
  logic [31:0] word_a = '0;
  logic [31:0] word_b = '0;
  logic [31:0] high_bits = '0;
  logic [15:0] d_half = '0;
  logic [15:0] dmin_half = '0;
  logic [7:0]  factor0 = '0;
  logic [7:0]  factor1 = '0;
  logic [7:0]  factor2 = '0;
  logic [7:0]  factor3 = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_data = '0;
  logic        result_valid;
  logic [9:0]  element_index;
  logic [31:0] value_a;
  logic [31:0] value_b;
  logic        last;
  int          cycles = 0;
  bit          no_gaps = 1'b0;
  weight_scoreboard sb = new();

  kquant_lane_dequantizer DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .lane(lane),
    .word_a(word_a), .word_b(word_b), .high_bits(high_bits), .d_half(d_half),
    .dmin_half(dmin_half), .factor0(factor0), .factor1(factor1), .factor2(factor2),
    .factor3(factor3), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_data(cfg_data), .result_valid(result_valid), .element_index(element_index),
    .value_a(value_a), .value_b(value_b), .last(last)
  );

  // Clock with a 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Run limit and result monitor.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > RUN_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
    if (!rst && result_valid) sb.check_result(element_index, value_a, value_b, last);
  end

  // Sends one request after a random gap and notes it once accepted.
  task automatic send_request(logic [5:0] ln, logic [31:0] wa, logic [31:0] wb,
                              logic [31:0] hw, logic [15:0] dh, logic [15:0] dmh,
                              logic [31:0] fw);
    int gap;
    logic [7:0] f[4];
    gap = no_gaps ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    lane = ln; word_a = wa; word_b = wb; high_bits = hw; d_half = dh; dmin_half = dmh;
    {factor3, factor2, factor1, factor0} = fw;
    f = '{fw[7:0], fw[15:8], fw[23:16], fw[31:24]};
    start = 1'b1;
    do @(posedge clk); while (busy);
    sb.note_request(ln, wa, wb, hw, dh, dmh, f);
    @(negedge clk);
  endtask

  // Lets every outstanding result drain before the format changes.
  task automatic drain_results();
    start = 1'b0;
    while (sb.pending_pairs.size() != 0) @(negedge clk);
    repeat (LANE_LAT + 8) @(negedge clk);
  endtask

  task automatic write_format(logic [1:0] v);
    cfg_valid = 1'b1;
    cfg_data = v;
    do @(posedge clk); while (!cfg_ready);
    sb.format = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Draws half bits that are mostly ordinary but often special.
  function automatic logic [15:0] pick_half();
    logic [15:0] specials[8];
    specials = '{16'h0001, 16'h03ff, 16'h7c00, 16'hfc00, 16'h7e01, 16'h7d55,
                 16'h8000, 16'h7bff};
    case ($urandom_range(0, 5))
      0: return specials[$urandom_range(0, 7)];
      1: return 16'($urandom);
      default: return {1'($urandom), 5'($urandom_range(8, 22)), 10'($urandom)};
    endcase
  endfunction

  task automatic random_requests(int n);
    for (int i = 0; i < n; i++) begin
      send_request(6'($urandom), $urandom, $urandom, $urandom, pick_half(), pick_half(),
                   $urandom);
    end
  endtask

  // Directed corner requests for the current format.
  task automatic directed_requests();
    send_request(6'd0, 32'h0, 32'h0, 32'h0, 16'h3c00, 16'h3c00, 32'h0);
    send_request(6'd63, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 16'h7bff, 16'hfbff,
                 32'hffff_ffff);
    send_request(6'd21, 32'h1234_5678, 32'h9abc_def0, 32'h5555_aaaa, 16'h0001, 16'h03ff,
                 32'h80_7f_01_ff);
    send_request(6'd42, 32'hf0f0_0f0f, 32'h0f0f_f0f0, 32'haaaa_5555, 16'h7c00, 16'h3800,
                 32'h00_3f_40_80);
    send_request(6'd7, 32'h8888_1111, 32'h7777_eeee, 32'h0f0f_f0f0, 16'h7e01, 16'hfc00,
                 32'h01_02_03_04);
    send_request(6'd50, 32'hffff_ffff, 32'h0, 32'hcccc_3333, 16'h8000, 16'h7d55,
                 32'hff_00_ff_00);
  endtask

  // Phases over all format codes, the unused code among them.
  initial begin
    logic [1:0] plan[7];
    plan = '{FMT_Q5, FMT_Q6, 2'd3, FMT_Q4, FMT_Q6, FMT_Q5, FMT_Q4};
    repeat (4) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);
    directed_requests();
    drain_results();
    for (int p = 0; p < 7; p++) begin
      write_format(plan[p]);
      if (p < 3) directed_requests();
      no_gaps = (p % 3 == 1);
      random_requests(42);
      drain_results();
    end
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
`default_nettype wire
